// ===== sv/pcxrle_pkg.sv =====
package pcxrle_pkg;

  // run length limit and the marker bits of a count byte
  localparam logic [5:0] RunMax    = 6'h3f;
  localparam logic [1:0] CountMark = 2'b11;

  localparam int unsigned QueueDepthDefault = 4;

  typedef struct packed {
    logic [7:0] pixel;
    logic       line_end;
  } pcxrle_in_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       line_done;
  } pcxrle_out_t;

  // one run to be written out
  typedef struct packed {
    logic       vld;
    logic [7:0] value;
    logic [5:0] count;
  } pcxrle_run_t;

  // queue entry: the closed run, then the flushed run at line end
  typedef struct packed {
    pcxrle_run_t run_a;
    pcxrle_run_t run_b;
    logic        line_end;
  } pcxrle_entry_t;

  typedef enum logic [1:0] {
    SlotCountA = 2'd0,
    SlotValueA = 2'd1,
    SlotCountB = 2'd2,
    SlotValueB = 2'd3
  } pcxrle_slot_e;

  // a count byte is needed for runs longer than one or values that look like counts
  function automatic logic needs_count(pcxrle_run_t run);
    return (run.count > 6'd1) || (run.value[7:6] == CountMark);
  endfunction

endpackage

// ===== sv/pcxrle_front.sv =====
module pcxrle_front import pcxrle_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pcxrle_in_t    in_req_i,
  input  logic          full_i,
  output logic          push_o,
  output pcxrle_entry_t entry_o
);

  logic [7:0] prev_q, prev_d;
  logic [5:0] run_q, run_d;
  logic       started_q, started_d;
  logic       accept;
  logic [5:0] run_inc;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign run_inc    = run_q + 6'd1;

  always_comb begin
    prev_d    = prev_q;
    run_d     = run_q;
    started_d = started_q;
    entry_o   = '0;

    if (!started_q) begin
      prev_d    = in_req_i.pixel;
      run_d     = 6'd1;
      started_d = 1'b1;
    end else if (in_req_i.pixel == prev_q) begin
      if (run_inc == RunMax) begin
        entry_o.run_a = '{vld: 1'b1, value: prev_q, count: RunMax};
        run_d         = 6'd0;
      end else begin
        run_d = run_inc;
      end
    end else begin
      if (run_q != 6'd0) begin
        entry_o.run_a = '{vld: 1'b1, value: prev_q, count: run_q};
      end
      prev_d = in_req_i.pixel;
      run_d  = 6'd1;
    end

    if (in_req_i.line_end) begin
      if (run_d != 6'd0) begin
        entry_o.run_b = '{vld: 1'b1, value: prev_d, count: run_d};
      end
      run_d     = 6'd0;
      started_d = 1'b0;
    end

    entry_o.line_end = in_req_i.line_end;
    push_o = accept && (entry_o.run_a.vld || entry_o.run_b.vld);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= '0;
      run_q     <= '0;
      started_q <= 1'b0;
    end else if (accept) begin
      prev_q    <= prev_d;
      run_q     <= run_d;
      started_q <= started_d;
    end
  end

endmodule

// ===== sv/pcxrle_queue.sv =====
module pcxrle_queue import pcxrle_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pcxrle_entry_t wdata_i,
  output logic          full_o,
  output logic          head_vld_o,
  output pcxrle_entry_t head_o,
  input  logic          pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pcxrle_entry_t       mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q, cnt_d;

  assign full_o     = (cnt_q == CntW'(Depth));
  assign head_vld_o = (cnt_q != '0);
  assign head_o     = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

endmodule

// ===== sv/pcxrle_back.sv =====
module pcxrle_back import pcxrle_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_vld_i,
  input  pcxrle_entry_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pcxrle_out_t   out_req_o
);

  logic [3:0]   done_q;
  logic [3:0]   slot_mask, pend, sel_bit, rest;
  pcxrle_slot_e sel;
  logic         take, last_byte;
  logic [7:0]   byte_sel;
  logic         out_vld_q;
  pcxrle_out_t  out_q;

  assign slot_mask = {head_i.run_b.vld,
                      head_i.run_b.vld && needs_count(head_i.run_b),
                      head_i.run_a.vld,
                      head_i.run_a.vld && needs_count(head_i.run_a)};
  assign pend = slot_mask & ~done_q;

  always_comb begin
    if (pend[0]) begin
      sel = SlotCountA;
    end else if (pend[1]) begin
      sel = SlotValueA;
    end else if (pend[2]) begin
      sel = SlotCountB;
    end else begin
      sel = SlotValueB;
    end
    sel_bit = 4'b0001 << sel;
    case (sel)
      SlotCountA: byte_sel = {CountMark, head_i.run_a.count};
      SlotValueA: byte_sel = head_i.run_a.value;
      SlotCountB: byte_sel = {CountMark, head_i.run_b.count};
      SlotValueB: byte_sel = head_i.run_b.value;
      default:    byte_sel = head_i.run_b.value;
    endcase
  end

  assign rest      = pend & ~sel_bit;
  assign last_byte = (rest == 4'b0000);
  assign take      = !out_vld_q || !out_stall_i;
  assign pop_o     = head_vld_i && take && last_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      done_q    <= '0;
    end else if (take) begin
      out_vld_q <= head_vld_i;
      if (head_vld_i) begin
        done_q <= last_byte ? 4'b0000 : (done_q | sel_bit);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && head_vld_i) begin
      out_q.code_byte <= byte_sel;
      out_q.line_done <= last_byte && head_i.line_end;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_req_o   = out_q;

endmodule

// ===== sv/pcx_rle_line_encoder.sv =====
// closed runs pass through the run queue and then the back end's output register
// throughput: one pixel per cycle; the back end writes one code byte per cycle unless
//   the output stalls, so pixels giving two to four bytes drain more slowly and stall
//   input once the run queue (QueueDepth entries) is full
// reset: asynchronous active low, clears run state, queue pointers and output valid
module pcx_rle_line_encoder import pcxrle_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // pixel requests
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  pcxrle_in_t  in_req_i,
  // code byte requests
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output pcxrle_out_t out_req_o
);

  // front to queue
  logic          push;
  pcxrle_entry_t entry;
  logic          full;

  // queue to back
  logic          head_vld;
  pcxrle_entry_t head;
  logic          pop;

  // front end: tracks the current run, closes runs and flushes at line end
  pcxrle_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (entry)
  );

  // short run queue decouples pixel intake from byte output
  pcxrle_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .wdata_i    (entry),
    .full_o     (full),
    .head_vld_o (head_vld),
    .head_o     (head),
    .pop_i      (pop)
  );

  // back end: expands each entry into count and value bytes, one per cycle unless the output stalls
  pcxrle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_vld_i  (head_vld),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule
